// File: src/vcs_pkg.sv
// Shared types, constants and helper functions of the velocity command shaper.
`default_nettype none

package vcs_pkg;

	// Field widths.
	localparam int KEY_W      = 8;
	localparam int STATE_W    = 24;
	localparam int CLAMP_W    = 23;
	localparam int WIDE_W     = 27;
	localparam int LIN_W      = 26;
	localparam int ANG_W      = 23;
	localparam int PROD_W     = 42;
	localparam int FRAC_BITS  = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 22;

	// Saturation limits of the linear command, held at the wide working width.
	localparam logic signed [WIDE_W-1:0] LIN_MAX = 27'sd33554431;
	localparam logic signed [WIDE_W-1:0] LIN_MIN = -27'sd33554432;

	// Key codes.
	localparam logic [KEY_W-1:0] KEY_W_LO  = 8'h77;
	localparam logic [KEY_W-1:0] KEY_S_LO  = 8'h73;
	localparam logic [KEY_W-1:0] KEY_W_UP  = 8'h57;
	localparam logic [KEY_W-1:0] KEY_S_UP  = 8'h53;
	localparam logic [KEY_W-1:0] KEY_A_LO  = 8'h61;
	localparam logic [KEY_W-1:0] KEY_A_UP  = 8'h41;
	localparam logic [KEY_W-1:0] KEY_D_LO  = 8'h64;
	localparam logic [KEY_W-1:0] KEY_D_UP  = 8'h44;
	localparam logic [KEY_W-1:0] KEY_SPACE = 8'h20;
	localparam logic [KEY_W-1:0] KEY_Q_LO  = 8'h71;
	localparam logic [KEY_W-1:0] KEY_Q_UP  = 8'h51;

	// Register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SPD_INC     = 3'd0,
		REG_ANG_INC     = 3'd1,
		REG_SPD_LIMIT   = 3'd2,
		REG_ANG_LIMIT   = 3'd3,
		REG_RAMP_GAIN   = 3'd4,
		REG_SPEED_DECAY = 3'd5,
		REG_ANGLE_DECAY = 3'd6,
		REG_ZERO_THRESH = 3'd7
	} reg_idx_t;

	// Reset values of the registers.
	localparam logic [16:0] RST_SPD_INC     = 17'd1311;
	localparam logic [18:0] RST_ANG_INC     = 19'd32768;
	localparam logic [21:0] RST_SPD_LIMIT   = 22'd1310720;
	localparam logic [21:0] RST_ANG_LIMIT   = 22'd655360;
	localparam logic [16:0] RST_RAMP_GAIN   = 17'd72090;
	localparam logic [16:0] RST_SPEED_DECAY = 17'd58982;
	localparam logic [16:0] RST_ANGLE_DECAY = 17'd49152;
	localparam logic [15:0] RST_ZERO_THRESH = 16'd66;

	typedef struct packed {
		logic [16:0] spd_inc;
		logic [18:0] ang_inc;
		logic [21:0] spd_limit;
		logic [21:0] ang_limit;
		logic [16:0] ramp_gain;
		logic [16:0] speed_decay;
		logic [16:0] angle_decay;
		logic [15:0] zero_threshold;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_APPLY,
		ST_DEC_S,
		ST_DEC_A,
		ST_OUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_RAMP,
		MUL_SPEED,
		MUL_ANGLE
	} mul_sel_t;

	// Controller to datapath.
	typedef struct packed {
		logic     load_key;
		logic     apply;
		logic     upd_speed;
		logic     finish;
		mul_sel_t mul_sel;
	} cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic out_free;
	} sts_t;

	// Magnitudes below the threshold become zero.
	function automatic logic signed [STATE_W-1:0] snap_zero(
		input logic signed [STATE_W-1:0] v,
		input logic [15:0]               thr
	);
		logic [STATE_W-1:0] mag;
		mag = v[STATE_W-1] ? STATE_W'(-v) : STATE_W'(v);
		return (mag < STATE_W'(thr)) ? '0 : v;
	endfunction

endpackage

`default_nettype wire

// File: src/velocity_command_shaper_unit.sv
// Top level of the velocity command shaper: register file, controller and datapath.
//
//  Channel  Signals                                        Direction  Beat taken when
//  input    in_valid, in_ready, key_valid, key_code        in         in_valid && in_ready
//  output   out_valid, out_ready, linear_cmd,              out        out_valid && out_ready
//           angular_cmd, quit_seen
//  config   cfg_we, cfg_index, cfg_data                    in         cfg_we
//
// One input beat passes through the idle step in which it is taken, while the shared
// multiplier forms the ramp product, a step that applies the key and clamps, a speed decay
// step and an angle decay step that form the decay products, each registered before use,
// and a last step that stores the angle and loads the output register.
// A result may wait in the output register while the block returns to idle and takes the
// next beat; the block only stalls in its last step if the previous result is still unread.
// Reset clears speed, angle, hold and all handshake state, and loads the register defaults.
// Configuration is to be written only while no beat is in flight.
`default_nettype none

module velocity_command_shaper_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// Input channel.
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                key_valid,
	input  logic [vcs_pkg::KEY_W-1:0]           key_code,
	// Output channel.
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vcs_pkg::LIN_W-1:0]    linear_cmd,
	output logic signed [vcs_pkg::ANG_W-1:0]    angular_cmd,
	output logic                                quit_seen,
	// Configuration write port.
	input  logic                                cfg_we,
	input  logic [vcs_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [vcs_pkg::CFG_DATA_W-1:0]      cfg_data
);
	import vcs_pkg::*;

	cfg_t cfg;
	cmd_t cmd;
	sts_t sts;

	// The register file holds the eight tuning values; they feed the datapath directly.
	vcs_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The controller steps each beat through apply, speed decay, angle decay and output.
	vcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// The datapath keeps speed, angle and hold, and owns the output register, so the
	// controller only learns whether that register can take a new result.
	vcs_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.cmd         (cmd),
		.sts         (sts),
		.key_valid   (key_valid),
		.key_code    (key_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.quit_seen   (quit_seen)
	);

endmodule

`default_nettype wire

// File: src/vcs_regs.sv
// Configuration register file of the velocity command shaper.
`default_nettype none

module vcs_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [vcs_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [vcs_pkg::CFG_DATA_W-1:0]  cfg_data,
	output vcs_pkg::cfg_t                   cfg
);
	import vcs_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.spd_inc        <= RST_SPD_INC;
			cfg_q.ang_inc        <= RST_ANG_INC;
			cfg_q.spd_limit      <= RST_SPD_LIMIT;
			cfg_q.ang_limit      <= RST_ANG_LIMIT;
			cfg_q.ramp_gain      <= RST_RAMP_GAIN;
			cfg_q.speed_decay    <= RST_SPEED_DECAY;
			cfg_q.angle_decay    <= RST_ANGLE_DECAY;
			cfg_q.zero_threshold <= RST_ZERO_THRESH;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_SPD_INC:     cfg_q.spd_inc        <= cfg_data[16:0];
				REG_ANG_INC:     cfg_q.ang_inc        <= cfg_data[18:0];
				REG_SPD_LIMIT:   cfg_q.spd_limit      <= cfg_data[21:0];
				REG_ANG_LIMIT:   cfg_q.ang_limit      <= cfg_data[21:0];
				REG_RAMP_GAIN:   cfg_q.ramp_gain      <= cfg_data[16:0];
				REG_SPEED_DECAY: cfg_q.speed_decay    <= cfg_data[16:0];
				REG_ANGLE_DECAY: cfg_q.angle_decay    <= cfg_data[16:0];
				REG_ZERO_THRESH: cfg_q.zero_threshold <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: src/vcs_ctrl.sv
// Sequencing state machine of the velocity command shaper.
`default_nettype none

module vcs_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output vcs_pkg::cmd_t cmd,
	input  vcs_pkg::sts_t sts
);
	import vcs_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		cmd         = '0;
		cmd.mul_sel = MUL_RAMP;
		unique case (state_q)
			ST_IDLE: begin
				in_ready     = 1'b1;
				cmd.load_key = in_valid;
				if (in_valid) begin
					state_d = ST_APPLY;
				end
			end
			ST_APPLY: begin
				cmd.apply = 1'b1;
				state_d   = ST_DEC_S;
			end
			ST_DEC_S: begin
				cmd.mul_sel = MUL_SPEED;
				state_d     = ST_DEC_A;
			end
			ST_DEC_A: begin
				cmd.mul_sel   = MUL_ANGLE;
				cmd.upd_speed = 1'b1;
				state_d       = ST_OUT;
			end
			ST_OUT: begin
				// Keep the angle product in the register while the result waits.
				cmd.mul_sel = MUL_ANGLE;
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result written while the output register is still full");

	a_accept_to_apply: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_APPLY))
		else $error("accepted beat not followed by the apply step");

	a_apply_once: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.apply |=> !cmd.apply)
		else $error("key update applied twice to one beat");

endmodule

`default_nettype wire

// File: src/vcs_datapath.sv
// Datapath of the velocity command shaper: state, shared multiplier and output register.
`default_nettype none

module vcs_datapath (
	input  logic                                clk,
	input  logic                                arst_n,
	input  vcs_pkg::cfg_t                       cfg,
	input  vcs_pkg::cmd_t                       cmd,
	output vcs_pkg::sts_t                       sts,
	input  logic                                key_valid,
	input  logic [vcs_pkg::KEY_W-1:0]           key_code,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [vcs_pkg::LIN_W-1:0]    linear_cmd,
	output logic signed [vcs_pkg::ANG_W-1:0]    angular_cmd,
	output logic                                quit_seen
);
	import vcs_pkg::*;

	// Captured input beat.
	logic                     key_valid_q;
	logic [KEY_W-1:0]         key_code_q;

	// Persistent state.
	logic signed [STATE_W-1:0] speed_q;
	logic signed [STATE_W-1:0] angle_q;
	logic                      hold_q;

	// Working registers.
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [CLAMP_W-1:0] sp_c_q;
	logic signed [CLAMP_W-1:0] an_c_q;
	logic signed [LIN_W-1:0]   lin_q;
	logic                      quit_q;

	// Output register.
	logic                      out_valid_q;
	logic signed [LIN_W-1:0]   linear_q;
	logic signed [ANG_W-1:0]   angular_q;
	logic                      quit_out_q;

	logic signed [STATE_W-1:0] mul_a;
	logic [16:0]               mul_b;
	logic signed [PROD_W-1:0]  prod_d;

	logic signed [WIDE_W-1:0]  sp_cur, an_cur, step, ramp_val, sp_k, an_k;
	logic signed [WIDE_W-1:0]  lim_sp, lim_an, sp_cl, an_cl, lin_full, lin_sat;
	logic                      hold_d, quit_d;
	logic signed [STATE_W-1:0] decayed;

	// Shared multiplier, one product a cycle.
	always_comb begin
		case (cmd.mul_sel)
			MUL_SPEED: begin
				mul_a = STATE_W'(sp_c_q);
				mul_b = cfg.speed_decay;
			end
			MUL_ANGLE: begin
				mul_a = STATE_W'(an_c_q);
				mul_b = cfg.angle_decay;
			end
			default: begin
				mul_a = speed_q;
				mul_b = cfg.ramp_gain;
			end
		endcase
	end

	assign prod_d = PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));

	// Floored fixed-point results of the registered product.
	assign ramp_val = WIDE_W'($signed(prod_q[PROD_W-1:FRAC_BITS]));
	assign decayed  = prod_q[STATE_W+FRAC_BITS-1:FRAC_BITS];

	// Key update, then independent symmetric clamps.
	always_comb begin
		sp_cur = WIDE_W'(speed_q);
		an_cur = WIDE_W'(angle_q);
		step   = $signed(WIDE_W'(cfg.spd_inc));
		sp_k   = sp_cur;
		an_k   = an_cur;
		hold_d = hold_q;
		quit_d = 1'b0;
		if (key_valid_q) begin
			unique case (key_code_q) inside
				KEY_W_LO: begin
					hold_d = 1'b0;
					sp_k   = sp_cur + step;
				end
				KEY_S_LO: begin
					hold_d = 1'b0;
					sp_k   = sp_cur - step;
				end
				KEY_W_UP: begin
					hold_d = 1'b1;
					if (sp_cur >= step) begin
						sp_k = ramp_val;
					end else if (sp_cur <= -step) begin
						sp_k = '0;
					end else begin
						sp_k = step;
					end
				end
				KEY_S_UP: begin
					hold_d = 1'b1;
					if (sp_cur <= -step) begin
						sp_k = ramp_val;
					end else if (sp_cur >= step) begin
						sp_k = '0;
					end else begin
						sp_k = -step;
					end
				end
				KEY_A_LO, KEY_A_UP: an_k = an_cur + $signed(WIDE_W'(cfg.ang_inc));
				KEY_D_LO, KEY_D_UP: an_k = an_cur - $signed(WIDE_W'(cfg.ang_inc));
				KEY_SPACE: begin
					sp_k = '0;
					an_k = '0;
				end
				KEY_Q_LO, KEY_Q_UP: begin
					sp_k   = '0;
					an_k   = '0;
					quit_d = 1'b1;
				end
				default: ;
			endcase
		end

		lim_sp = $signed(WIDE_W'(cfg.spd_limit));
		lim_an = $signed(WIDE_W'(cfg.ang_limit));
		if (sp_k > lim_sp) begin
			sp_cl = lim_sp;
		end else if (sp_k < -lim_sp) begin
			sp_cl = -lim_sp;
		end else begin
			sp_cl = sp_k;
		end
		if (an_k > lim_an) begin
			an_cl = lim_an;
		end else if (an_k < -lim_an) begin
			an_cl = -lim_an;
		end else begin
			an_cl = an_k;
		end

		// Ten times the speed as shift and add, then saturate.
		lin_full = (sp_cl <<< 3) + (sp_cl <<< 1);
		if (lin_full > LIN_MAX) begin
			lin_sat = LIN_MAX;
		end else if (lin_full < LIN_MIN) begin
			lin_sat = LIN_MIN;
		end else begin
			lin_sat = lin_full;
		end
	end

	always_ff @(posedge clk) begin
		prod_q <= prod_d;
		if (cmd.load_key) begin
			key_valid_q <= key_valid;
			key_code_q  <= key_code;
		end
		if (cmd.apply) begin
			sp_c_q <= sp_cl[CLAMP_W-1:0];
			an_c_q <= an_cl[CLAMP_W-1:0];
			lin_q  <= lin_sat[LIN_W-1:0];
			quit_q <= quit_d;
		end
		if (cmd.finish) begin
			linear_q   <= lin_q;
			angular_q  <= an_c_q;
			quit_out_q <= quit_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_q     <= '0;
			angle_q     <= '0;
			hold_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.apply) begin
				hold_q <= hold_d;
			end
			if (cmd.upd_speed) begin
				speed_q <= snap_zero(hold_q ? STATE_W'(sp_c_q) : decayed,
					cfg.zero_threshold);
			end
			if (cmd.finish) begin
				angle_q     <= snap_zero(decayed, cfg.zero_threshold);
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign linear_cmd   = linear_q;
	assign angular_cmd  = angular_q;
	assign quit_seen    = quit_out_q;

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result did not reach the output register");

	a_quit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && quit_seen) |-> (linear_cmd == '0 && angular_cmd == '0))
		else $error("quit result carries a non-zero command");

endmodule

`default_nettype wire

// File: sim/testbench.sv
// Self-checking testbench of the velocity command shaper: paced key beats and a predictor.

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import vcs_pkg::*;

	// One key beat as offered on the input channel.
	typedef struct packed {
		logic             kv;
		logic [KEY_W-1:0] kc;
	} key_beat_t;

	// One result beat as the output channel should carry it.
	typedef struct packed {
		logic signed [LIN_W-1:0] lin;
		logic signed [ANG_W-1:0] ang;
		logic                    quit;
	} shaped_cmd_t;

	localparam int RANDOM_PER_PHASE = 150;
	localparam int PHASE_COUNT      = 8;
	localparam int MAX_WAIT         = 18;
	localparam int LONG_HOLD        = 320;
	localparam int DRAIN_CYCLES     = 10;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  in_valid   = 1'b0;
	logic                  in_ready;
	logic                  key_valid  = 1'b0;
	logic [KEY_W-1:0]      key_code   = '0;
	logic                  out_valid;
	logic                  out_ready  = 1'b0;
	logic signed [LIN_W-1:0] linear_cmd;
	logic signed [ANG_W-1:0] angular_cmd;
	logic                  quit_seen;
	logic                  cfg_we     = 1'b0;
	reg_idx_t              cfg_index  = REG_SPD_INC;
	logic [CFG_DATA_W-1:0] cfg_data   = '0;

	velocity_command_shaper_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.key_valid   (key_valid),
		.key_code    (key_code),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.linear_cmd  (linear_cmd),
		.angular_cmd (angular_cmd),
		.quit_seen   (quit_seen),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	always #6 clk = ~clk;

	// Predictor state: our own copy of the registers, speed, angle and hold.
	cfg_t   shaper_cfg;
	longint speed_now;
	longint angle_now;
	logic   hold_now;

	key_beat_t   pending_keys[$];
	shaped_cmd_t expected_cmds[$];

	int keys_queued     = 0;
	int results_checked = 0;
	int error_count     = 0;
	int send_gap_max    = MAX_WAIT;
	int recv_gap_max    = MAX_WAIT;
	int send_wait       = 0;
	int recv_wait       = 0;
	logic in_taken      = 1'b0;
	logic out_taken     = 1'b0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d, expected %0d", what, got, want);
		error_count++;
	endtask

	function automatic logic [CFG_DATA_W-1:0] default_of(input reg_idx_t idx);
		case (idx)
			REG_SPD_INC:     return CFG_DATA_W'(RST_SPD_INC);
			REG_ANG_INC:     return CFG_DATA_W'(RST_ANG_INC);
			REG_SPD_LIMIT:   return CFG_DATA_W'(RST_SPD_LIMIT);
			REG_ANG_LIMIT:   return CFG_DATA_W'(RST_ANG_LIMIT);
			REG_RAMP_GAIN:   return CFG_DATA_W'(RST_RAMP_GAIN);
			REG_SPEED_DECAY: return CFG_DATA_W'(RST_SPEED_DECAY);
			REG_ANGLE_DECAY: return CFG_DATA_W'(RST_ANGLE_DECAY);
			default:         return CFG_DATA_W'(RST_ZERO_THRESH);
		endcase
	endfunction

	// Top of the documented range of each register; the port itself allows more.
	function automatic int unsigned range_top(input reg_idx_t idx);
		case (idx)
			REG_SPD_INC:     return 65536;
			REG_ANG_INC:     return 262144;
			REG_SPD_LIMIT:   return 2097152;
			REG_ANG_LIMIT:   return 2097152;
			REG_RAMP_GAIN:   return 131071;
			REG_SPEED_DECAY: return 65536;
			REG_ANGLE_DECAY: return 65536;
			default:         return 65535;
		endcase
	endfunction

	// Each register keeps only its own low bits of the written word.
	function automatic void store_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SPD_INC:     shaper_cfg.spd_inc        = data[16:0];
			REG_ANG_INC:     shaper_cfg.ang_inc        = data[18:0];
			REG_SPD_LIMIT:   shaper_cfg.spd_limit      = data[21:0];
			REG_ANG_LIMIT:   shaper_cfg.ang_limit      = data[21:0];
			REG_RAMP_GAIN:   shaper_cfg.ramp_gain      = data[16:0];
			REG_SPEED_DECAY: shaper_cfg.speed_decay    = data[16:0];
			REG_ANGLE_DECAY: shaper_cfg.angle_decay    = data[16:0];
			default:         shaper_cfg.zero_threshold = data[15:0];
		endcase
	endfunction

	// Fixed point product with 16 fraction bits, floored.
	function automatic longint scale_fx(input longint v, input longint factor);
		return (v * factor) >>> FRAC_BITS;
	endfunction

	function automatic longint clamp_to(input longint v, input longint lim);
		if (v > lim)
			return lim;
		if (v < -lim)
			return -lim;
		return v;
	endfunction

	function automatic longint snap_small(input longint v);
		longint mag;
		mag = (v < 0) ? -v : v;
		return (mag < longint'(shaper_cfg.zero_threshold)) ? 0 : v;
	endfunction

	// One control tick: apply the key, clamp, form the result, then decay and snap.
	function automatic shaped_cmd_t shape_tick(input logic kv, input logic [KEY_W-1:0] kc);
		longint      sp;
		longint      an;
		longint      step;
		longint      lin;
		shaped_cmd_t res;
		sp       = speed_now;
		an       = angle_now;
		step     = longint'(shaper_cfg.spd_inc);
		res.quit = 1'b0;
		if (kv) begin
			case (kc)
				KEY_W_LO: begin
					hold_now = 1'b0;
					sp += step;
				end
				KEY_S_LO: begin
					hold_now = 1'b0;
					sp -= step;
				end
				KEY_W_UP: begin
					hold_now = 1'b1;
					if (sp >= step)
						sp = scale_fx(sp, longint'(shaper_cfg.ramp_gain));
					else if (sp <= -step)
						sp = 0;
					else
						sp = step;
				end
				KEY_S_UP: begin
					hold_now = 1'b1;
					if (sp <= -step)
						sp = scale_fx(sp, longint'(shaper_cfg.ramp_gain));
					else if (sp >= step)
						sp = 0;
					else
						sp = -step;
				end
				KEY_A_LO, KEY_A_UP: an += longint'(shaper_cfg.ang_inc);
				KEY_D_LO, KEY_D_UP: an -= longint'(shaper_cfg.ang_inc);
				KEY_SPACE: begin
					sp = 0;
					an = 0;
				end
				KEY_Q_LO, KEY_Q_UP: begin
					sp       = 0;
					an       = 0;
					res.quit = 1'b1;
				end
				default: ;
			endcase
		end
		sp = clamp_to(sp, longint'(shaper_cfg.spd_limit));
		an = clamp_to(an, longint'(shaper_cfg.ang_limit));
		// Ten times the speed saturates to the width of the linear command.
		lin = sp * 10;
		if (lin > longint'(LIN_MAX))
			lin = longint'(LIN_MAX);
		if (lin < longint'(LIN_MIN))
			lin = longint'(LIN_MIN);
		res.lin = lin[LIN_W-1:0];
		res.ang = an[ANG_W-1:0];
		if (!hold_now)
			sp = scale_fx(sp, longint'(shaper_cfg.speed_decay));
		an        = scale_fx(an, longint'(shaper_cfg.angle_decay));
		speed_now = snap_small(sp);
		angle_now = snap_small(an);
		return res;
	endfunction

	task automatic push_key(input logic kv, input logic [KEY_W-1:0] kc);
		key_beat_t b;
		b.kv = kv;
		b.kc = kc;
		pending_keys.push_back(b);
		keys_queued++;
	endtask

	// Writes land at the next rising edge; the predictor copy follows at once, as
	// nothing is in flight while registers change.
	task automatic write_reg(input reg_idx_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		store_reg(idx, data);
	endtask

	// Every key beat gives exactly one result, so the block is idle once the counts meet.
	task automatic wait_drained();
		while (results_checked != keys_queued)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Setting 0 puts every bit high, 1 clears everything, 2 restores the defaults, and
	// later settings pick per register among zero, all ones, in range and any value.
	task automatic load_setting(input int setting);
		reg_idx_t              idx;
		logic [CFG_DATA_W-1:0] val;
		idx = idx.first();
		repeat (idx.num()) begin
			case (setting)
				0: val = '1;
				1: val = '0;
				2: val = default_of(idx);
				default: begin
					case ($urandom_range(0, 3))
						0: val = '0;
						1: val = '1;
						2: val = CFG_DATA_W'($urandom);
						default: val = CFG_DATA_W'($urandom_range(0, range_top(idx)));
					endcase
				end
			endcase
			write_reg(idx, val);
			idx = idx.next();
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly runs of real keys, so ramps, holds and clamps build up, with some stray
	// codes and empty ticks mixed in.
	task automatic push_random_keys(input int count);
		int               n;
		int               pick;
		int               reps;
		logic [KEY_W-1:0] kc;
		n = 0;
		while (n < count) begin
			pick = $urandom_range(0, 99);
			reps = $urandom_range(1, 5);
			if (pick < 30)
				kc = $urandom_range(0, 1) ? KEY_W_LO : KEY_S_LO;
			else if (pick < 50)
				kc = $urandom_range(0, 1) ? KEY_W_UP : KEY_S_UP;
			else if (pick < 72) begin
				case ($urandom_range(0, 3))
					0: kc = KEY_A_LO;
					1: kc = KEY_A_UP;
					2: kc = KEY_D_LO;
					default: kc = KEY_D_UP;
				endcase
			end else if (pick < 76) begin
				reps = 1;
				case ($urandom_range(0, 2))
					0: kc = KEY_SPACE;
					1: kc = KEY_Q_LO;
					default: kc = KEY_Q_UP;
				endcase
			end else
				reps = 1;
			repeat (reps) begin
				if (pick < 76)
					push_key(1'b1, kc);
				else
					push_key(pick < 88, KEY_W'($urandom));
				n++;
			end
		end
	endtask

	// Sampling at the rising edge: the predictor runs on every accepted key beat, and
	// every accepted result is checked against the oldest prediction.
	always @(posedge clk) begin : watch_beats
		shaped_cmd_t want;
		in_taken  <= in_valid && in_ready;
		out_taken <= out_valid && out_ready;
		if (arst_n && in_valid && in_ready)
			expected_cmds.push_back(shape_tick(key_valid, key_code));
		if (arst_n && out_valid && out_ready) begin
			results_checked <= results_checked + 1;
			if (expected_cmds.size() == 0)
				report_mismatch("result with none expected, linear", linear_cmd, 0);
			else begin
				want = expected_cmds.pop_front();
				if (linear_cmd !== want.lin)
					report_mismatch("linear_cmd", linear_cmd, want.lin);
				if (angular_cmd !== want.ang)
					report_mismatch("angular_cmd", angular_cmd, want.ang);
				if (quit_seen !== want.quit)
					report_mismatch("quit_seen", quit_seen, want.quit);
			end
		end
	end

	// Sender: holds each beat until it is taken, then waits a drawn number of cycles.
	always @(negedge clk) begin : send_keys
		key_beat_t nb;
		if (!in_valid || in_taken) begin
			if (send_wait > 0) begin
				send_wait--;
				in_valid <= 1'b0;
			end else if (pending_keys.size() != 0) begin
				nb = pending_keys.pop_front();
				in_valid  <= 1'b1;
				key_valid <= nb.kv;
				key_code  <= nb.kc;
				send_wait = $urandom_range(0, send_gap_max);
			end else
				in_valid <= 1'b0;
		end
	end

	// Receiver: after each result it stalls for a drawn number of cycles. Now and then
	// it holds off for a long stretch so that the block fills and stops taking keys.
	always @(negedge clk) begin : take_results
		if (out_taken) begin
			if (results_checked % 500 == 250)
				recv_wait = LONG_HOLD;
			else
				recv_wait = $urandom_range(0, recv_gap_max);
		end
		if (recv_wait > 0) begin
			recv_wait--;
			out_ready <= 1'b0;
		end else
			out_ready <= 1'b1;
	end

	initial begin : stimulus
		reg_idx_t idx;
		// The predictor starts from the register defaults with speed, angle and hold cleared.
		idx = idx.first();
		repeat (idx.num()) begin
			store_reg(idx, default_of(idx));
			idx = idx.next();
		end
		speed_now = 0;
		angle_now = 0;
		hold_now  = 1'b0;

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed ticks on the default registers: steps, ramps from below one step,
		// ramps that reverse to zero, both signs of the ramp, every turn key, the stops,
		// an empty tick carrying a live code, and both ends of the key code.
		push_key(1'b1, KEY_W_LO);
		push_key(1'b1, KEY_W_LO);
		push_key(1'b1, KEY_W_LO);
		push_key(1'b1, KEY_W_UP);
		push_key(1'b1, KEY_W_UP);
		push_key(1'b1, KEY_S_UP);
		push_key(1'b1, KEY_S_UP);
		push_key(1'b1, KEY_S_UP);
		push_key(1'b1, KEY_W_UP);
		push_key(1'b1, KEY_S_LO);
		push_key(1'b1, KEY_A_LO);
		push_key(1'b1, KEY_A_UP);
		push_key(1'b1, KEY_D_LO);
		push_key(1'b1, KEY_D_UP);
		push_key(1'b1, KEY_SPACE);
		push_key(1'b1, KEY_W_LO);
		push_key(1'b1, KEY_Q_LO);
		push_key(1'b1, KEY_A_LO);
		push_key(1'b1, KEY_Q_UP);
		push_key(1'b0, KEY_W_LO);
		push_key(1'b1, '1);
		push_key(1'b1, '0);
		wait_drained();

		// Several register settings, each with its own pacing: both sides idling,
		// neither idling, and each side idling alone.
		for (int phase = 0; phase < PHASE_COUNT; phase++) begin
			load_setting(phase);
			send_gap_max = (phase % 4 < 2) ? MAX_WAIT : 0;
			recv_gap_max = (phase % 4 == 0 || phase % 4 == 3) ? MAX_WAIT : 0;
			push_random_keys(RANDOM_PER_PHASE);
			wait_drained();
		end

		if (expected_cmds.size() != 0)
			report_mismatch("predictions left over", expected_cmds.size(), 0);
		if (error_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#6_000_000;
		$display("status: fail");
		$finish;
	end

endmodule

// File: files.f
src/vcs_pkg.sv
src/vcs_regs.sv
src/vcs_ctrl.sv
src/vcs_datapath.sv
src/velocity_command_shaper_unit.sv
sim/testbench.sv
